[hw/rtl/mmmpq_pkg.sv]
// Shared constants, word types and codes for the min/max/median priority queue.
// No dependencies; every other file imports this package.

package mmmpq_pkg;

    // Sizing
    localparam int CAPACITY = 256;
    localparam int KEY_W    = 32;
    localparam int KT_W     = 9;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_RAW  = $clog2(CAPACITY);
    localparam int IDX_W    = (IDX_RAW < 2) ? 2 : IDX_RAW;
    localparam int LO_W     = IDX_W / 2;
    localparam int HI_W     = IDX_W - LO_W;
    localparam int NGRP     = 1 << HI_W;
    localparam int GSZ      = 1 << LO_W;

    // Opcodes
    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_DEL_MIN = 3'd1;
    localparam logic [2:0] OP_DEL_MAX = 3'd2;
    localparam logic [2:0] OP_DEL_MED = 3'd3;
    localparam logic [2:0] OP_STATUS  = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]              opcode;
        logic signed [KEY_W-1:0] new_key;
    } req_word_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] removed_key;
        logic [1:0]              status;
        logic [KT_W-1:0]         key_total;
        logic signed [KEY_W-1:0] min_key;
        logic signed [KEY_W-1:0] max_key;
        logic signed [KEY_W-1:0] median_key;
    } rsp_word_t;

    // Broadcast control to every cell of the row
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic signed [KEY_W-1:0] new_key;
        logic [CNT_W-1:0]        del_pos;
        logic [CNT_W-1:0]        count;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PICK,
        S_DONE
    } fsm_t;

endpackage

[hw/rtl/mmmpq_cell.sv]
// One cell of the sorted key row: holds a key, shifts with its neighbors.
// Depends on mmmpq_pkg.

module mmmpq_cell
    import mmmpq_pkg::*;
(
    input  logic                    clk,
    input  cell_ctrl_t              ctrl,
    input  logic [CNT_W-1:0]        idx,
    input  logic signed [KEY_W-1:0] left_key,
    input  logic                    left_gt,
    input  logic signed [KEY_W-1:0] right_key,
    output logic signed [KEY_W-1:0] key,
    output logic                    gt
);

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic                    occ;

    // Empty cells count as greater than any new key
    assign occ = idx < ctrl.count;
    assign gt  = !occ || ($signed(key_reg) > $signed(ctrl.new_key));

    // Insert opens a gap at the first greater cell; delete closes one at del_pos
    always_comb
    begin
        key_next = key_reg;
        priority if (ctrl.ins)
        begin
            if (left_gt)
                key_next = left_key;
            else if (gt)
                key_next = ctrl.new_key;
        end
        else if (ctrl.del)
        begin
            if (idx >= ctrl.del_pos)
                key_next = right_key;
        end
        else
        begin
            key_next = key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

[hw/rtl/mmmpq_chain.sv]
// Row of CAPACITY key cells kept in ascending order.
// Depends on mmmpq_pkg and mmmpq_cell.

module mmmpq_chain
    import mmmpq_pkg::*;
(
    input  logic                              clk,
    input  cell_ctrl_t                        ctrl,
    output logic [CAPACITY-1:0][KEY_W-1:0]    keys
);

    logic [CAPACITY-1:0] gt;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [KEY_W-1:0] lkey;
            logic signed [KEY_W-1:0] rkey;
            logic                    lgt;
            logic signed [KEY_W-1:0] ckey;

            // Row ends see a constant neighbor
            if (i == 0)
            begin : g_first
                assign lkey = '0;
                assign lgt  = 1'b0;
            end
            else
            begin : g_mid_l
                assign lkey = keys[i-1];
                assign lgt  = gt[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign rkey = '0;
            end
            else
            begin : g_mid_r
                assign rkey = keys[i+1];
            end

            mmmpq_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .idx       (CNT_W'(i)),
                .left_key  (lkey),
                .left_gt   (lgt),
                .right_key (rkey),
                .key       (ckey),
                .gt        (gt[i])
            );

            assign keys[i] = ckey;
        end
    endgenerate

endmodule

[hw/rtl/mmmpq_sel.sv]
// Two-level registered selection of the max and median keys from the row.
// Depends on mmmpq_pkg.

module mmmpq_sel
    import mmmpq_pkg::*;
(
    input  logic                           clk,
    input  logic [CAPACITY-1:0][KEY_W-1:0] keys,
    input  logic                           load,
    input  logic [IDX_W-1:0]               max_pos,
    input  logic [IDX_W-1:0]               med_pos,
    output logic signed [KEY_W-1:0]        max_key,
    output logic signed [KEY_W-1:0]        median_key
);

    logic [NGRP-1:0][KEY_W-1:0] cmax_reg;
    logic [NGRP-1:0][KEY_W-1:0] cmax_next;
    logic [NGRP-1:0][KEY_W-1:0] cmed_reg;
    logic [NGRP-1:0][KEY_W-1:0] cmed_next;
    logic [HI_W-1:0]            max_hi_reg;
    logic [HI_W-1:0]            med_hi_reg;

    // First level: the chosen column of every group
    always_comb
    begin
        cmax_next = cmax_reg;
        cmed_next = cmed_reg;
        for (int g = 0; g < NGRP; g++)
        begin
            cmax_next[g] = '0;
            cmed_next[g] = '0;
            for (int j = 0; j < GSZ; j++)
            begin
                if (g * GSZ + j < CAPACITY)
                begin
                    if (max_pos[LO_W-1:0] == LO_W'(j))
                        cmax_next[g] = keys[g * GSZ + j];
                    if (med_pos[LO_W-1:0] == LO_W'(j))
                        cmed_next[g] = keys[g * GSZ + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmax_reg   <= cmax_next;
            cmed_reg   <= cmed_next;
            max_hi_reg <= max_pos[IDX_W-1:LO_W];
            med_hi_reg <= med_pos[IDX_W-1:LO_W];
        end
    end

    // Second level: the chosen group
    assign max_key    = cmax_reg[max_hi_reg];
    assign median_key = cmed_reg[med_hi_reg];

endmodule

[hw/rtl/min_max_median_priority_queue.sv]
// Top level of the min/max/median priority queue: control, count, output word.
// Depends on mmmpq_pkg, mmmpq_chain (with mmmpq_cell) and mmmpq_sel.
//
//  channel | valid      | stall      | word | moves
//  --------+------------+------------+------+-------------------------------
//  request | req_valid  | req_stall  | req  | opcode and key into the block
//  result  | rsp_valid  | rsp_stall  | rsp  | one status word per request
//
// A request word passes S_IDLE, S_PICK and S_DONE in order: the accept edge updates the
// cell row in one shot, S_PICK registers the group picks for max and median, and S_DONE
// loads the result register. The block takes no new word until that load; the pace is
// set by the two-level max/median selection.
// Reset clears the key count, the sequence state and the result valid flag;
// cell contents are never read above the count.
// A stalled result holds the last stage; the request side stalls until it moves.

module min_max_median_priority_queue
    import mmmpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    fsm_t             state_reg;
    fsm_t             state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_word_t        rsp_reg;
    rsp_word_t        rsp_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic signed [KEY_W-1:0] removed_reg;
    logic signed [KEY_W-1:0] removed_next;

    logic             accept;
    logic             pick_load;
    logic             rsp_load;
    cell_ctrl_t       ctrl;
    logic [CAPACITY-1:0][KEY_W-1:0] keys;
    logic [CNT_W-1:0] last_pos;
    logic [IDX_W-1:0] max_pos;
    logic [IDX_W-1:0] med_pos;
    logic signed [KEY_W-1:0] sel_max;
    logic signed [KEY_W-1:0] sel_med;

    // Control sequence
    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        pick_load  = 1'b0;
        rsp_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                    state_next = S_PICK;
            end
            S_PICK:
            begin
                pick_load  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign accept   = req_valid && !req_stall;
    assign last_pos = count_reg - CNT_W'(1);

    // Opcode decode; removed key comes from the row head or the last result
    always_comb
    begin
        ctrl         = '0;
        ctrl.new_key = req.new_key;
        ctrl.count   = count_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        if (accept)
        begin
            status_next  = ST_OK;
            removed_next = '0;
            unique case (req.opcode)
                OP_INSERT:
                begin
                    if (count_reg >= CNT_W'(CAPACITY))
                        status_next = ST_FULL;
                    else
                    begin
                        ctrl.ins   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_DEL_MIN, OP_DEL_MAX, OP_DEL_MED:
                begin
                    if (count_reg == '0)
                        status_next = ST_EMPTY;
                    else
                    begin
                        ctrl.del   = 1'b1;
                        count_next = last_pos;
                        if (req.opcode == OP_DEL_MIN)
                        begin
                            ctrl.del_pos = '0;
                            removed_next = keys[0];
                        end
                        else if (req.opcode == OP_DEL_MAX)
                        begin
                            ctrl.del_pos = last_pos;
                            removed_next = rsp_reg.max_key;
                        end
                        else
                        begin
                            ctrl.del_pos = last_pos >> 1;
                            removed_next = rsp_reg.median_key;
                        end
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    mmmpq_chain u_chain (
        .clk  (clk),
        .ctrl (ctrl),
        .keys (keys)
    );

    // Positions in the updated row
    assign max_pos = IDX_W'(last_pos);
    assign med_pos = IDX_W'(last_pos >> 1);

    mmmpq_sel u_sel (
        .clk        (clk),
        .keys       (keys),
        .load       (pick_load),
        .max_pos    (max_pos),
        .med_pos    (med_pos),
        .max_key    (sel_max),
        .median_key (sel_med)
    );

    // Result word register
    always_comb
    begin
        rsp_next             = rsp_reg;
        rsp_valid_next       = rsp_valid_reg && rsp_stall;
        if (rsp_load)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.removed_key = removed_reg;
            rsp_next.status      = status_reg;
            rsp_next.key_total   = KT_W'(count_reg);
            if (count_reg == '0)
            begin
                rsp_next.min_key    = '0;
                rsp_next.max_key    = '0;
                rsp_next.median_key = '0;
            end
            else
            begin
                rsp_next.min_key    = keys[0];
                rsp_next.max_key    = sel_max;
                rsp_next.median_key = sel_med;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // Count never goes past the row length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("key count above capacity");

    // Count moves only on an accepted word, and by one at most
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ($past(accept) && ((count_reg == $past(count_reg) + CNT_W'(1)) ||
                               (count_reg == $past(count_reg) - CNT_W'(1)))))
        else $error("key count changed without an accepted word");

    // Accepted word starts the selection sequence
    a_accept_pick: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_PICK))
        else $error("accepted word did not start selection");

    // A new result appears only out of the final stage
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside the final stage");
`endif

endmodule
